>>> hdl/spq_pkg.sv
// Package for the sorted priority queue.
// Field widths, operation and status codes, and the command that drives the cell row.
// No dependencies.
package spq_pkg;

  localparam int ID_W      = 16;
  localparam int PRI_W     = 16;
  localparam int OCC_W     = 9;
  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_CHANGE  = 2'd2;
  localparam logic [1:0] OP_REMOVE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic                    head;
    logic [ID_W-1:0]         id;
    logic signed [PRI_W-1:0] pri;
  } cell_cmd_t;

endpackage

>>> hdl/spq_req_if.sv
// Request channel of the sorted priority queue: valid, ready and one operation.
// Depends on spq_pkg.
interface spq_req_if import spq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [ID_W-1:0]         item_id;
  logic signed [PRI_W-1:0] priority_req;

  modport source (output valid, operation, item_id, priority_req, input ready);
  modport sink (input valid, operation, item_id, priority_req, output ready);
endinterface

>>> hdl/spq_rsp_if.sv
// Response channel of the sorted priority queue: valid, ready and one result.
// Depends on spq_pkg.
interface spq_rsp_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  result_id;
  logic [1:0]       status;
  logic [OCC_W-1:0] occupancy;
  logic             is_empty;

  modport source (output valid, result_id, status, occupancy, is_empty, input ready);
  modport sink (input valid, result_id, status, occupancy, is_empty, output ready);
endinterface

>>> hdl/spq_cell.sv
// One slot of the sorted row: holds an id and a priority, compares against the
// command and takes the new entry or a neighbor's entry. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic                    occ,
  input  logic                    left_le,
  input  logic [ID_W-1:0]         left_id,
  input  logic signed [PRI_W-1:0] left_pri,
  input  logic [ID_W-1:0]         right_id,
  input  logic signed [PRI_W-1:0] right_pri,
  input  logic                    hit_in,
  output logic [ID_W-1:0]         id,
  output logic signed [PRI_W-1:0] pri,
  output logic                    le,
  output logic                    hit_out
);

  logic [ID_W-1:0]         id_next;
  logic signed [PRI_W-1:0] pri_next;

  assign le      = occ && (pri <= cmd.pri);
  assign hit_out = hit_in || (occ && (id == cmd.id));

  always_comb begin
    id_next  = id;
    pri_next = pri;
    if (cmd.ins && !le) begin
      if (left_le) begin
        id_next  = cmd.id;
        pri_next = cmd.pri;
      end else begin
        id_next  = left_id;
        pri_next = left_pri;
      end
    end else if (cmd.head || (cmd.del && hit_out)) begin
      id_next  = right_id;
      pri_next = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    id  <= id_next;
    pri <= pri_next;
  end

endmodule

>>> hdl/sorted_priority_queue_top.sv
// Sorted priority queue top level: cell row, entry count, sequencer, result register.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
//
// Usage:
//   req carries one operation per beat (insert, extract minimum, change
//   priority, remove by id) with an item id and a signed Q8.8 priority.
//   rsp returns one beat per request: extracted id, status, occupancy and
//   an empty flag, in request order.
//   Insert, extract, remove and a change priority of an absent id finish in
//   the cycle they are accepted; the result beat is valid in the next cycle.
//   Change priority of a present id removes in the accept cycle and inserts
//   in the next, so its result beat is loaded by the re-insert and req is
//   held off while that re-insert runs.
//   Throughput is one request per cycle while rsp does not stall; a change
//   priority that finds its id holds req off for its re-insert; the sequencer
//   and the single command broadcast to all cells set this figure.
//   All cells compare against the command in parallel and shift one place
//   toward a neighbor at most, so the row stays sorted with ties in arrival
//   order.
//   Reset empties the queue at once; slot contents are left as they are.
//   When rsp stalls, the result waits in its register and req is accepted
//   only once that register is free or draining in the same cycle.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_REINS = 1'b1;

  logic                    state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [ID_W-1:0]         held_id;
  logic signed [PRI_W-1:0] held_pri;

  logic                    accept;
  logic                    full;
  logic                    found;
  cell_cmd_t               cmd;

  logic [ID_W-1:0]         cell_id  [DEPTH];
  logic signed [PRI_W-1:0] cell_pri [DEPTH];
  logic [DEPTH-1:0]        cell_le;
  logic [DEPTH-1:0]        cell_hit;
  logic [DEPTH-1:0]        occ;

  logic                    load;
  logic [ID_W-1:0]         rid_next;
  logic [1:0]              status_next;

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign found     = cell_hit[DEPTH-1];

  always_comb begin
    cmd.id   = (state == S_REINS) ? held_id : req.item_id;
    cmd.pri  = (state == S_REINS) ? held_pri : req.priority_req;
    cmd.ins  = (state == S_REINS) || (accept && req.operation == OP_INSERT && !full);
    cmd.head = accept && req.operation == OP_EXTRACT && count != '0;
    cmd.del  = accept && (req.operation == OP_CHANGE || req.operation == OP_REMOVE);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = CW'(i) < count;
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .occ      (occ[i]),
        .left_le  (1'b1),
        .left_id  (cmd.id),
        .left_pri (cmd.pri),
        .right_id (cell_id[i+1]),
        .right_pri(cell_pri[i+1]),
        .hit_in   (1'b0),
        .id       (cell_id[i]),
        .pri      (cell_pri[i]),
        .le       (cell_le[i]),
        .hit_out  (cell_hit[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .occ      (occ[i]),
        .left_le  (cell_le[i-1]),
        .left_id  (cell_id[i-1]),
        .left_pri (cell_pri[i-1]),
        .right_id (cell_id[i]),
        .right_pri(cell_pri[i]),
        .hit_in   (cell_hit[i-1]),
        .id       (cell_id[i]),
        .pri      (cell_pri[i]),
        .le       (cell_le[i]),
        .hit_out  (cell_hit[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .occ      (occ[i]),
        .left_le  (cell_le[i-1]),
        .left_id  (cell_id[i-1]),
        .left_pri (cell_pri[i-1]),
        .right_id (cell_id[i+1]),
        .right_pri(cell_pri[i+1]),
        .hit_in   (cell_hit[i-1]),
        .id       (cell_id[i]),
        .pri      (cell_pri[i]),
        .le       (cell_le[i]),
        .hit_out  (cell_hit[i])
      );
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.head || (cmd.del && found)) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    load        = 1'b0;
    rid_next    = '0;
    status_next = ST_OK;
    if (state == S_REINS) begin
      load = 1'b1;
    end else if (accept) begin
      unique case (req.operation)
        OP_INSERT: begin
          load = 1'b1;
          if (full) begin
            status_next = ST_FULL;
          end
        end
        OP_EXTRACT: begin
          load = 1'b1;
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            rid_next = cell_id[0];
          end
        end
        OP_CHANGE: begin
          load = !found;
          if (!found) begin
            status_next = ST_NOTFOUND;
          end
        end
        OP_REMOVE: begin
          load = 1'b1;
          if (!found) begin
            status_next = ST_NOTFOUND;
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (state == S_REINS) begin
        state <= S_IDLE;
      end else if (accept && req.operation == OP_CHANGE && found) begin
        state <= S_REINS;
      end
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_id  <= req.item_id;
      held_pri <= req.priority_req;
    end
    if (load) begin
      rsp.result_id <= rid_next;
      rsp.status    <= status_next;
      rsp.occupancy <= OCC_W'(count_next);
      rsp.is_empty  <= (count_next == '0);
    end
  end

endmodule

>>> test/tb_sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Testbench for sorted_priority_queue_top: directed table, then phased random traffic,
// each reply checked against its table entry or a shadow copy of the sorted store.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the RTL of the queue.
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int QDEPTH         = DEPTH_DEF;
  localparam int NUM_DIR        = 23;
  localparam int RAND_ITEMS     = 1100;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
  } reply_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [ID_W-1:0]         id;
    logic signed [PRI_W-1:0] pri;
    logic                    known;
    reply_t                  want;
  } dir_row_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [ID_W-1:0]         shadow_ids  [QDEPTH];
  logic signed [PRI_W-1:0] shadow_pris [QDEPTH];
  int                      shadow_count;
  reply_t                  exp_replies [$];
  int                      mismatches;

  dir_row_t dir_tab [NUM_DIR] = '{
    '{OP_EXTRACT, 16'h0000, 16'sh0000, 1'b1, '{16'h0000, ST_EMPTY,    9'd0, 1'b1}},
    '{OP_REMOVE,  16'h0005, 16'sh0000, 1'b1, '{16'h0000, ST_NOTFOUND, 9'd0, 1'b1}},
    '{OP_CHANGE,  16'h0005, 16'sh0100, 1'b1, '{16'h0000, ST_NOTFOUND, 9'd0, 1'b1}},
    '{OP_INSERT,  16'hFFFF, 16'sh7FFF, 1'b1, '{16'h0000, ST_OK,       9'd1, 1'b0}},
    '{OP_INSERT,  16'h0000, 16'sh8000, 1'b1, '{16'h0000, ST_OK,       9'd2, 1'b0}},
    '{OP_EXTRACT, 16'h0000, 16'sh0000, 1'b1, '{16'h0000, ST_OK,       9'd1, 1'b0}},
    '{OP_INSERT,  16'h1234, 16'sh7FFF, 1'b0, '0},
    '{OP_INSERT,  16'h8001, 16'sh7FFF, 1'b0, '0},
    '{OP_EXTRACT, 16'h0000, 16'sh0000, 1'b1, '{16'hFFFF, ST_OK,       9'd2, 1'b0}},
    '{OP_INSERT,  16'h0007, 16'sh0000, 1'b0, '0},
    '{OP_INSERT,  16'h0007, 16'shFFFF, 1'b0, '0},
    '{OP_REMOVE,  16'h0007, 16'sh0000, 1'b0, '0},
    '{OP_CHANGE,  16'h0007, 16'sh7FFF, 1'b0, '0},
    '{OP_CHANGE,  16'h1234, 16'sh8000, 1'b0, '0},
    '{OP_REMOVE,  16'hAAAA, 16'sh0000, 1'b0, '0},
    '{OP_EXTRACT, 16'hFFFF, 16'sh7FFF, 1'b0, '0},
    '{OP_EXTRACT, 16'h0000, 16'sh8000, 1'b0, '0},
    '{OP_EXTRACT, 16'h5A5A, 16'sh0000, 1'b0, '0},
    '{OP_EXTRACT, 16'h0000, 16'sh0000, 1'b1, '{16'h0000, ST_EMPTY,    9'd0, 1'b1}},
    '{OP_INSERT,  16'h5555, 16'sh00FF, 1'b0, '0},
    '{OP_INSERT,  16'hAAAA, 16'shFF00, 1'b0, '0},
    '{OP_REMOVE,  16'h5555, 16'sh0000, 1'b0, '0},
    '{OP_REMOVE,  16'hAAAA, 16'sh0000, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void shadow_insert(input logic [ID_W-1:0] id,
                                        input logic signed [PRI_W-1:0] pri);
    int pos;
    int i;
    pos = 0;
    while (pos < shadow_count && shadow_pris[pos] <= pri) pos++;
    for (i = shadow_count; i > pos; i--) begin
      shadow_ids[i]  = shadow_ids[i-1];
      shadow_pris[i] = shadow_pris[i-1];
    end
    shadow_ids[pos]  = id;
    shadow_pris[pos] = pri;
    shadow_count++;
  endfunction

  function automatic void shadow_delete(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++) begin
      shadow_ids[i]  = shadow_ids[i+1];
      shadow_pris[i] = shadow_pris[i+1];
    end
    shadow_count--;
  endfunction

  function automatic reply_t next_reply(input logic [1:0] op, input logic [ID_W-1:0] id,
                                        input logic signed [PRI_W-1:0] pri);
    reply_t r;
    int     pos;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= QDEPTH) r.status = ST_FULL;
        else shadow_insert(id, pri);
      end
      OP_EXTRACT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_id = shadow_ids[0];
          shadow_delete(0);
        end
      end
      default: begin
        pos = 0;
        while (pos < shadow_count && shadow_ids[pos] != id) pos++;
        if (pos >= shadow_count) begin
          r.status = ST_NOTFOUND;
        end else begin
          shadow_delete(pos);
          if (op == OP_CHANGE) shadow_insert(id, pri);
        end
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send_op(input logic [1:0] op, input logic [ID_W-1:0] id,
                         input logic signed [PRI_W-1:0] pri, input int gap,
                         input logic known, input reply_t want);
    reply_t r;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.item_id      <= id;
    req_ch.priority_req <= pri;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    r = next_reply(op, id, pri);
    exp_replies.push_back(known ? want : r);
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (exp_replies.size() == 0) begin
        report_mismatch("reply with none pending", rsp_ch.result_id, 16'h0);
      end else begin
        e = exp_replies.pop_front();
        if (rsp_ch.result_id !== e.result_id)
          report_mismatch("result_id", rsp_ch.result_id, e.result_id);
        if (rsp_ch.status !== e.status)
          report_mismatch("status", 16'(rsp_ch.status), 16'(e.status));
        if (rsp_ch.occupancy !== e.occupancy)
          report_mismatch("occupancy", 16'(rsp_ch.occupancy), 16'(e.occupancy));
        if (rsp_ch.is_empty !== e.is_empty)
          report_mismatch("is_empty", 16'(rsp_ch.is_empty), 16'(e.is_empty));
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and two long hold-offs to back up req.
  initial begin
    int  stall_left;
    int  beats;
    logic took;
    stall_left   = 0;
    beats        = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = !rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1;
      if (took) begin
        beats++;
        if (beats == 100 || beats == 700) stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (took && ((beats / 150) % 3 != 1)) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int              n;
    int              sent;
    int              phase_kind;
    int              phase_len;
    int              k;
    int              r;
    int              gap;
    logic            burst;
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] id_pool [8];
    logic signed [PRI_W-1:0] pri;

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_INSERT;
    req_ch.item_id      = '0;
    req_ch.priority_req = '0;
    shadow_count        = 0;
    mismatches          = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < NUM_DIR; n++) begin
      send_op(dir_tab[n].op, dir_tab[n].id, dir_tab[n].pri, pick_gap(),
              dir_tab[n].known, dir_tab[n].want);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(40, 120);
      burst      = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 8; k++) id_pool[k] = 16'($urandom);
      for (k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (phase_kind)
          0: op = (r < 65) ? OP_INSERT : (r < 75) ? OP_EXTRACT : (r < 90) ? OP_CHANGE : OP_REMOVE;
          1: op = (r < 15) ? OP_INSERT : (r < 70) ? OP_EXTRACT : (r < 85) ? OP_CHANGE : OP_REMOVE;
          default: op = 2'(r % 4);
        endcase
        id = ($urandom_range(0, 4) != 0) ? id_pool[$urandom_range(0, 7)] : 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 4) pri = 16'(int'($urandom_range(0, 7)) - 4);
        else if (r < 8) pri = 16'($urandom);
        else if (r == 8) pri = 16'sh7FFF;
        else pri = 16'sh8000;
        gap = burst ? 0 : pick_gap();
        send_op(op, id, pri, gap, 1'b0, '0);
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    while (exp_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
